// ===== rtl/irlq_pkg.sv =====
// ----------------------------------------------------------------------------
// irlq_pkg
// Shared types, register codes and linearisation tables for the infrared
// rangefinder linearise-and-qualify block.
// ----------------------------------------------------------------------------
package irlq_pkg;

    localparam int DIST_W   = 8;
    localparam int WARMUP_W = 3;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_AUTONOMOUS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CORRIDOR   = 2'd1;

    localparam logic [DIST_W-1:0] CORRIDOR_RESET = 8'd60;

    localparam logic [7:0] LONG_LO   = 8'd22;
    localparam logic [7:0] LONG_HI   = 8'd138;
    localparam logic [7:0] LONG_FAR  = 8'd150;
    localparam logic [7:0] LONG_NEAR = 8'd16;

    localparam logic [7:0] SHORT_LO   = 8'd19;
    localparam logic [7:0] SHORT_HI   = 8'd140;
    localparam logic [7:0] SHORT_FAR  = 8'd90;
    localparam logic [7:0] SHORT_NEAR = 8'd8;

    localparam logic [7:0] LONG_CM [0:116] = '{
        8'd16, 8'd16, 8'd17, 8'd17, 8'd18, 8'd18, 8'd19, 8'd19, 8'd20, 8'd20, 8'd20,
        8'd21, 8'd21, 8'd21, 8'd22, 8'd22, 8'd23, 8'd23, 8'd23, 8'd24, 8'd24,
        8'd24, 8'd25, 8'd25, 8'd25, 8'd26, 8'd26, 8'd27, 8'd27, 8'd27, 8'd28,
        8'd28, 8'd28, 8'd29, 8'd29, 8'd30, 8'd30, 8'd30, 8'd31, 8'd31, 8'd32,
        8'd32, 8'd33, 8'd33, 8'd33, 8'd34, 8'd34, 8'd35, 8'd35, 8'd35, 8'd36,
        8'd36, 8'd37, 8'd37, 8'd38, 8'd38, 8'd38, 8'd39, 8'd39, 8'd40, 8'd40,
        8'd41, 8'd41, 8'd42, 8'd42, 8'd43, 8'd43, 8'd44, 8'd44, 8'd45, 8'd46,
        8'd47, 8'd48, 8'd49, 8'd50, 8'd51, 8'd53, 8'd54, 8'd55, 8'd56, 8'd58,
        8'd59, 8'd60, 8'd60, 8'd61, 8'd62, 8'd63, 8'd63, 8'd64, 8'd64, 8'd65,
        8'd67, 8'd68, 8'd70, 8'd73, 8'd75, 8'd78, 8'd80, 8'd82, 8'd84, 8'd86,
        8'd88, 8'd90, 8'd93, 8'd97, 8'd100, 8'd105, 8'd110, 8'd113, 8'd117,
        8'd120, 8'd125, 8'd130, 8'd135, 8'd140, 8'd145, 8'd150
    };

    localparam logic [7:0] SHORT_CM [0:121] = '{
        8'd8, 8'd8, 8'd8, 8'd8, 8'd8, 8'd8, 8'd9, 8'd9, 8'd9, 8'd9, 8'd9, 8'd9,
        8'd9, 8'd9, 8'd9, 8'd9, 8'd9, 8'd10, 8'd10, 8'd10, 8'd10, 8'd10,
        8'd10, 8'd10, 8'd10, 8'd10, 8'd11, 8'd11, 8'd11, 8'd11, 8'd11, 8'd11,
        8'd11, 8'd12, 8'd12, 8'd12, 8'd12, 8'd12, 8'd12, 8'd13,
        8'd13, 8'd13, 8'd13, 8'd13, 8'd13, 8'd13, 8'd14, 8'd14, 8'd14, 8'd14,
        8'd14, 8'd14, 8'd14, 8'd15, 8'd15, 8'd15, 8'd15, 8'd15,
        8'd16, 8'd16, 8'd16, 8'd16, 8'd17, 8'd17, 8'd17, 8'd18, 8'd18, 8'd18,
        8'd19, 8'd19, 8'd19, 8'd19, 8'd20, 8'd20, 8'd20, 8'd21,
        8'd21, 8'd22, 8'd22, 8'd23, 8'd23, 8'd23, 8'd24, 8'd24, 8'd25, 8'd25,
        8'd26, 8'd26, 8'd27, 8'd28, 8'd28, 8'd29, 8'd29, 8'd30,
        8'd31, 8'd32, 8'd33, 8'd34, 8'd36, 8'd37, 8'd38, 8'd39, 8'd40, 8'd41,
        8'd43, 8'd44, 8'd46, 8'd47, 8'd49, 8'd50, 8'd53, 8'd55,
        8'd58, 8'd60, 8'd63, 8'd65, 8'd68, 8'd70, 8'd75, 8'd80, 8'd85, 8'd90
    };

    typedef struct packed {
        logic [7:0] raw_front;
        logic [7:0] raw_left_front;
        logic [7:0] raw_right_front;
        logic [7:0] raw_left_back;
        logic [7:0] raw_right_back;
        logic       calibrate;
        logic       restart_history;
    } frame_t;

    typedef struct packed {
        logic [DIST_W-1:0] lf;
        logic [DIST_W-1:0] rf;
        logic [DIST_W-1:0] lb;
        logic [DIST_W-1:0] rb;
    } offsets_t;

    typedef struct packed {
        logic [DIST_W-1:0] front;
        logic [DIST_W-1:0] lf;
        logic [DIST_W-1:0] rf;
        logic [DIST_W-1:0] lb;
        logic [DIST_W-1:0] rb;
    } dists_t;

    typedef struct packed {
        dists_t dists;
        logic   warming_up;
        logic   stable;
        logic   in_corridor;
    } result_t;

    // control from the top level to the history unit
    typedef struct packed {
        logic advance;
        logic restart;
        logic shift;
    } hist_ctl_t;

    function automatic logic [7:0] long_range(input logic [7:0] code);
        logic [7:0] idx;
        idx = LONG_HI - code;
        if (code < LONG_LO)
            return LONG_FAR;
        else if (code > LONG_HI)
            return LONG_NEAR;
        else
            return LONG_CM[idx[6:0]];
    endfunction

    function automatic logic [7:0] short_range(input logic [7:0] code);
        logic [7:0] idx;
        idx = SHORT_HI - code;
        if (code < SHORT_LO)
            return SHORT_FAR;
        else if (code > SHORT_HI)
            return SHORT_NEAR;
        else
            return SHORT_CM[idx[6:0]];
    endfunction

    function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

// ===== rtl/irlq_ifs.sv =====
// ----------------------------------------------------------------------------
// irlq channel interfaces
// Valid/ready channels for sensor frames, results and register writes.
// ----------------------------------------------------------------------------
interface irlq_frame_if;
    logic       valid;
    logic       ready;
    logic [7:0] raw_front;
    logic [7:0] raw_left_front;
    logic [7:0] raw_right_front;
    logic [7:0] raw_left_back;
    logic [7:0] raw_right_back;
    logic       calibrate;
    logic       restart_history;

    modport source (
        output valid, raw_front, raw_left_front, raw_right_front,
               raw_left_back, raw_right_back, calibrate, restart_history,
        input  ready
    );
    modport sink (
        input  valid, raw_front, raw_left_front, raw_right_front,
               raw_left_back, raw_right_back, calibrate, restart_history,
        output ready
    );
endinterface

interface irlq_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] dist_front;
    logic [7:0] dist_left_front;
    logic [7:0] dist_right_front;
    logic [7:0] dist_left_back;
    logic [7:0] dist_right_back;
    logic       warming_up;
    logic       stable;
    logic       in_corridor;

    modport source (
        output valid, dist_front, dist_left_front, dist_right_front,
               dist_left_back, dist_right_back, warming_up, stable, in_corridor,
        input  ready
    );
    modport sink (
        input  valid, dist_front, dist_left_front, dist_right_front,
               dist_left_back, dist_right_back, warming_up, stable, in_corridor,
        output ready
    );
endinterface

interface irlq_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [irlq_pkg::CFG_IDX_W-1:0]  index;
    logic [7:0]                      data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/ir_range_linearize_and_qualify_top.sv =====
// ----------------------------------------------------------------------------
// ir_range_linearize_and_qualify_top
// Infrared rangefinder linearisation, side calibration and stability check.
// ----------------------------------------------------------------------------
// One frame enters an input register, passes combinationally through the
// table lookup, offset addition, calibration and history check and lands
// in a result register. A frame can be accepted every cycle while the sink
// takes each result; result valid rises as the frame moves from the input
// register into the result register, and a result held by a stalled sink
// still lets one more frame be taken into the input register. The first
// WARMUP_FRAMES frames report warming_up and never shift into the history.
// Configuration writes are taken at once (ready is always high).
// ----------------------------------------------------------------------------
module ir_range_linearize_and_qualify_top #(
    parameter int HISTORY_DEPTH = 10,
    parameter int WARMUP_FRAMES = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    irlq_cfg_if.sink      cfg,
    irlq_frame_if.sink    frame,
    irlq_result_if.source result
);

    localparam logic [irlq_pkg::WARMUP_W-1:0] WARMUP_LIMIT =
        irlq_pkg::WARMUP_W'(WARMUP_FRAMES);

    logic                                autonomous_reg;
    logic [irlq_pkg::DIST_W-1:0]         corridor_limit_reg;

    logic                                in_valid_reg;
    logic                                in_valid_next;
    irlq_pkg::frame_t                    in_reg;
    logic                                out_valid_reg;
    logic                                out_valid_next;
    irlq_pkg::result_t                   out_reg;
    irlq_pkg::result_t                   out_next;

    irlq_pkg::offsets_t                  offsets_reg;
    irlq_pkg::offsets_t                  offsets_next;
    logic [irlq_pkg::WARMUP_W-1:0]       warmup_count_reg;
    logic [irlq_pkg::WARMUP_W-1:0]       warmup_count_next;

    logic                                advance;
    logic                                take;
    logic                                warming;
    logic                                hist_stable;
    irlq_pkg::dists_t                    dists;
    irlq_pkg::hist_ctl_t                 hist_ctl;
    logic [irlq_pkg::DIST_W-1:0]         lf_delta;
    logic [irlq_pkg::DIST_W-1:0]         rf_delta;

    assign advance     = in_valid_reg && (!out_valid_reg || result.ready);
    assign frame.ready = !in_valid_reg || advance;
    assign take        = frame.valid && frame.ready;
    assign cfg.ready   = 1'b1;
    assign warming     = warmup_count_reg < WARMUP_LIMIT;

    assign hist_ctl.advance = advance;
    assign hist_ctl.restart = in_reg.restart_history;
    assign hist_ctl.shift   = advance && !warming && autonomous_reg;

    irlq_linearize u_linearize (
        .frame   (in_reg),
        .offsets (offsets_reg),
        .dists   (dists)
    );

    irlq_history #(
        .DEPTH (HISTORY_DEPTH)
    ) u_history (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (hist_ctl),
        .lf_cm  (dists.lf),
        .rf_cm  (dists.rf),
        .stable (hist_stable)
    );

    always_comb
    begin
        in_valid_next = take ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        out_valid_next = advance ? 1'b1 : (result.ready ? 1'b0 : out_valid_reg);

        // learn offsets from the wrapped front minus back difference
        lf_delta     = dists.lf - dists.lb;
        rf_delta     = dists.rf - dists.rb;
        offsets_next = offsets_reg;
        if (advance && in_reg.calibrate)
        begin
            if (lf_delta != '0)
            begin
                if (!lf_delta[irlq_pkg::DIST_W-1])
                    offsets_next.lb = lf_delta;
                else
                    offsets_next.lf = '0 - lf_delta;
            end
            if (rf_delta != '0)
            begin
                if (!rf_delta[irlq_pkg::DIST_W-1])
                    offsets_next.rb = rf_delta;
                else
                    offsets_next.rf = '0 - rf_delta;
            end
        end

        warmup_count_next = (advance && warming)
                            ? warmup_count_reg + irlq_pkg::WARMUP_W'(1)
                            : warmup_count_reg;

        out_next.dists       = dists;
        out_next.warming_up  = warming;
        out_next.stable      = hist_stable;
        out_next.in_corridor = hist_stable &&
                               (dists.lf < corridor_limit_reg) &&
                               (dists.rf < corridor_limit_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            autonomous_reg     <= 1'b0;
            corridor_limit_reg <= irlq_pkg::CORRIDOR_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                irlq_pkg::CFG_AUTONOMOUS: autonomous_reg     <= cfg.data[0];
                irlq_pkg::CFG_CORRIDOR:   corridor_limit_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            offsets_reg      <= '0;
            warmup_count_reg <= '0;
        end
        else
        begin
            in_valid_reg     <= in_valid_next;
            out_valid_reg    <= out_valid_next;
            offsets_reg      <= offsets_next;
            warmup_count_reg <= warmup_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_reg.raw_front       <= frame.raw_front;
            in_reg.raw_left_front  <= frame.raw_left_front;
            in_reg.raw_right_front <= frame.raw_right_front;
            in_reg.raw_left_back   <= frame.raw_left_back;
            in_reg.raw_right_back  <= frame.raw_right_back;
            in_reg.calibrate       <= frame.calibrate;
            in_reg.restart_history <= frame.restart_history;
        end
        if (advance)
            out_reg <= out_next;
    end

    assign result.valid            = out_valid_reg;
    assign result.dist_front       = out_reg.dists.front;
    assign result.dist_left_front  = out_reg.dists.lf;
    assign result.dist_right_front = out_reg.dists.rf;
    assign result.dist_left_back   = out_reg.dists.lb;
    assign result.dist_right_back  = out_reg.dists.rb;
    assign result.warming_up       = out_reg.warming_up;
    assign result.stable           = out_reg.stable;
    assign result.in_corridor      = out_reg.in_corridor;

    a_warmup_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.warming_up |-> !out_reg.stable && !out_reg.in_corridor)
        else $error("decision raised during warm-up");

    a_corridor_needs_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.in_corridor |-> out_reg.stable)
        else $error("corridor reported without stability");

    a_warmup_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        warmup_count_reg <= WARMUP_LIMIT)
        else $error("warm-up counter ran past its limit");

endmodule

// ===== rtl/irlq_linearize.sv =====
// ----------------------------------------------------------------------------
// irlq_linearize
// Table lookup of the five raw codes and addition of the side offsets.
// ----------------------------------------------------------------------------
module irlq_linearize (
    input  irlq_pkg::frame_t   frame,
    input  irlq_pkg::offsets_t offsets,
    output irlq_pkg::dists_t   dists
);

    always_comb
    begin
        dists.front = irlq_pkg::long_range(frame.raw_front);
        // side distances wrap modulo 256
        dists.lf    = irlq_pkg::long_range(frame.raw_left_front) + offsets.lf;
        dists.rf    = irlq_pkg::long_range(frame.raw_right_front) + offsets.rf;
        dists.lb    = irlq_pkg::short_range(frame.raw_left_back) + offsets.lb;
        dists.rb    = irlq_pkg::short_range(frame.raw_right_back) + offsets.rb;
    end

endmodule

// ===== rtl/irlq_history.sv =====
// ----------------------------------------------------------------------------
// irlq_history
// Front-side distance history and the parallel deviation check.
// ----------------------------------------------------------------------------
module irlq_history #(
    parameter int DEPTH = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  irlq_pkg::hist_ctl_t           ctl,
    input  logic [irlq_pkg::DIST_W-1:0]   lf_cm,
    input  logic [irlq_pkg::DIST_W-1:0]   rf_cm,
    output logic                          stable
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [irlq_pkg::DIST_W-1:0] left_hist_reg  [DEPTH];
    logic [irlq_pkg::DIST_W-1:0] right_hist_reg [DEPTH];
    logic [CNT_W-1:0]            valid_count_reg;
    logic [CNT_W-1:0]            valid_count_next;
    logic [CNT_W-1:0]            count_base;
    logic                        check_ok;

    always_comb
    begin
        count_base = ctl.restart ? '0 : valid_count_reg;
        if (ctl.shift && (count_base < CNT_W'(DEPTH)))
            valid_count_next = count_base + CNT_W'(1);
        else
            valid_count_next = count_base;

        // entry i of the shifted history is old entry i-1
        check_ok = (valid_count_next >= CNT_W'(3));
        for (int i = 1; i < DEPTH; i++)
        begin
            if (CNT_W'(i) < valid_count_next)
            begin
                if ((irlq_pkg::abs_diff(lf_cm, left_hist_reg[i-1]) > 8'(2 * i)) ||
                    (irlq_pkg::abs_diff(rf_cm, right_hist_reg[i-1]) > 8'(2 * i)))
                    check_ok = 1'b0;
            end
        end
        stable = ctl.shift && check_ok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_count_reg <= '0;
        else if (ctl.advance)
            valid_count_reg <= valid_count_next;
    end

    // entries beyond the valid count are never looked at, so no reset
    always_ff @(posedge clk)
    begin
        if (ctl.shift)
        begin
            left_hist_reg[0]  <= lf_cm;
            right_hist_reg[0] <= rf_cm;
            for (int i = 1; i < DEPTH; i++)
            begin
                left_hist_reg[i]  <= left_hist_reg[i-1];
                right_hist_reg[i] <= right_hist_reg[i-1];
            end
        end
    end

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        valid_count_reg <= CNT_W'(DEPTH))
        else $error("history valid count beyond depth");

    a_stable_needs_three: assert property (@(posedge clk) disable iff (!rst_n)
        stable |=> valid_count_reg >= CNT_W'(3))
        else $error("stable reported with fewer than three entries");

endmodule
